FILE: rtl/btn_dar_pkg.sv
// ============================================================================
// Button debounce and auto-repeat: shared constants
// Phase codes, event codes, register map and reset values.
// ============================================================================
`default_nettype none

package btn_dar_pkg;

  localparam int NUM_BUTTONS_DEF = 6;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int PIN_W   = 6;
  localparam int FIELDS  = 6;
  localparam int EV_W    = 2;
  localparam int REG_W   = 16;
  localparam int PH_W    = 3;
  localparam int ADDR_W  = 4;

  localparam logic [PH_W-1:0] PH_REL_CAND   = 3'd0;
  localparam logic [PH_W-1:0] PH_PRESS_CAND = 3'd1;
  localparam logic [PH_W-1:0] PH_IDLE       = 3'd2;
  localparam logic [PH_W-1:0] PH_WAIT_FIRST = 3'd3;
  localparam logic [PH_W-1:0] PH_REPEAT     = 3'd4;

  localparam logic [EV_W-1:0] EV_NONE     = 2'd0;
  localparam logic [EV_W-1:0] EV_RELEASED = 2'd1;
  localparam logic [EV_W-1:0] EV_PRESSED  = 2'd2;
  localparam logic [EV_W-1:0] EV_REPEAT   = 2'd3;

  localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [1:0] REG_FIRST_REPEAT = 2'd1;
  localparam logic [1:0] REG_REPEAT       = 2'd2;

  localparam logic [REG_W-1:0] DEBOUNCE_RST     = 16'd3;
  localparam logic [REG_W-1:0] FIRST_REPEAT_RST = 16'd50;
  localparam logic [REG_W-1:0] REPEAT_RST       = 16'd10;

endpackage

`default_nettype wire

FILE: rtl/button_debounce_autorepeat.sv
// ============================================================================
// Button debounce and auto-repeat
// Per-button phase machine and saturating tick counter kept in a small
// state memory, updated by read-modify-write once per button per tick.
// ============================================================================
// Each input request is one polling tick with the active-low pin levels;
// each tick yields one result request with an event code per button. The
// buttons of a tick go one per cycle through read-modify-write of the state
// memory, by its read port and separate write port, but the last button is
// held until the output register is free or being emptied. The next tick is
// taken as the last button of the current one is read.
// A finished result waits in an output register while the next tick runs.
// State entries are valid-tracked, so no clearing pass follows reset.
`default_nettype none

module button_debounce_autorepeat #(
  parameter int NUM_BUTTONS = btn_dar_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_WIDTH = btn_dar_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [5:0] pin_levels
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [1:0] up, [3:2] right, [5:4] down,
                                      // [7:6] left, [9:8] ok, [11:10] cancel
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int PAD_W = (NUM_BUTTONS > btn_dar_pkg::PIN_W) ? NUM_BUTTONS
                                                            : btn_dar_pkg::PIN_W;
  localparam int CMP_W = (COUNT_WIDTH > btn_dar_pkg::REG_W) ? COUNT_WIDTH
                                                            : btn_dar_pkg::REG_W;
  localparam int ACC_W = btn_dar_pkg::FIELDS * btn_dar_pkg::EV_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

  typedef struct packed {
    logic [btn_dar_pkg::PH_W-1:0] phase;
    logic [COUNT_WIDTH-1:0]       cnt;
  } entry_t;

  // configuration registers
  logic [btn_dar_pkg::REG_W-1:0] debounce_count;
  logic [btn_dar_pkg::REG_W-1:0] first_repeat_ticks;
  logic [btn_dar_pkg::REG_W-1:0] repeat_ticks;
  logic                          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count     <= btn_dar_pkg::DEBOUNCE_RST;
      first_repeat_ticks <= btn_dar_pkg::FIRST_REPEAT_RST;
      repeat_ticks       <= btn_dar_pkg::REPEAT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        btn_dar_pkg::REG_DEBOUNCE:     debounce_count     <= pwdata[15:0];
        btn_dar_pkg::REG_FIRST_REPEAT: first_repeat_ticks <= pwdata[15:0];
        btn_dar_pkg::REG_REPEAT:       repeat_ticks       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      btn_dar_pkg::REG_DEBOUNCE:     prdata = {16'd0, debounce_count};
      btn_dar_pkg::REG_FIRST_REPEAT: prdata = {16'd0, first_repeat_ticks};
      btn_dar_pkg::REG_REPEAT:       prdata = {16'd0, repeat_ticks};
      default:                       prdata = 32'd0;
    endcase
  end

  // tick holding register and button sequencer
  logic                           cur_valid;
  logic [btn_dar_pkg::PIN_W-1:0]  cur_pins;
  logic [IDX_W-1:0]               idx;
  logic [PAD_W-1:0]               pins_pad;
  logic                           at_last;
  logic                           out_ok;
  logic                           issue;

  // update stage
  logic                           b_valid;
  logic [IDX_W-1:0]               b_idx;
  logic                           b_pressed;
  logic                           b_first;
  logic                           b_last;

  // state memory
  entry_t                         mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]         written;
  entry_t                         rd_entry;
  logic                           rd_written;
  entry_t                         cur_entry;
  entry_t                         wr_entry;
  logic                           fwd;

  logic [ACC_W-1:0]               acc;
  logic [ACC_W-1:0]               acc_next;
  logic [btn_dar_pkg::EV_W-1:0]   ev;
  logic [COUNT_WIDTH-1:0]         cnt_inc;
  logic [btn_dar_pkg::REG_W-1:0]  deb_target;
  logic [btn_dar_pkg::REG_W-1:0]  rep_target;

  assign pins_pad = ~PAD_W'(~cur_pins);
  assign at_last  = (idx == LAST_IDX);
  assign out_ok   = (!m_tvalid || m_tready) && !(b_valid && b_last);
  assign issue    = cur_valid && (!at_last || out_ok);
  assign s_tready = !cur_valid || (issue && at_last);
  assign fwd      = b_valid && (b_idx == idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (s_tvalid && s_tready) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (issue) begin
      if (at_last) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cur_pins <= s_tdata[btn_dar_pkg::PIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_idx     <= idx;
      b_pressed <= ~pins_pad[idx];
      b_first   <= (idx == '0);
      b_last    <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      mem[b_idx] <= wr_entry;
    end
    if (issue) begin
      if (fwd) begin
        rd_entry <= wr_entry;
      end else begin
        rd_entry <= mem[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (b_valid) begin
        written[b_idx] <= 1'b1;
      end
      if (issue) begin
        rd_written <= fwd || written[idx];
      end
    end
  end

  // phase update
  always_comb begin
    cur_entry = rd_written ? rd_entry
                           : entry_t'{phase: btn_dar_pkg::PH_IDLE, cnt: '0};
    cnt_inc   = (cur_entry.cnt == '1) ? cur_entry.cnt
                                      : cur_entry.cnt + COUNT_WIDTH'(1);
    deb_target = debounce_count - 16'd1;
    rep_target = (cur_entry.phase == btn_dar_pkg::PH_WAIT_FIRST) ? first_repeat_ticks
                                                                 : repeat_ticks;
    wr_entry = '{phase: cur_entry.phase, cnt: cnt_inc};
    ev       = btn_dar_pkg::EV_NONE;
    unique case (cur_entry.phase) inside
      btn_dar_pkg::PH_REL_CAND, btn_dar_pkg::PH_PRESS_CAND: begin
        if (b_pressed != (cur_entry.phase == btn_dar_pkg::PH_PRESS_CAND)) begin
          wr_entry = '{phase: btn_dar_pkg::PH_IDLE, cnt: '0};
        end else if (CMP_W'(cnt_inc) == CMP_W'(deb_target)) begin
          if (cur_entry.phase == btn_dar_pkg::PH_REL_CAND) begin
            wr_entry = '{phase: btn_dar_pkg::PH_IDLE, cnt: '0};
            ev       = btn_dar_pkg::EV_RELEASED;
          end else begin
            wr_entry = '{phase: btn_dar_pkg::PH_WAIT_FIRST, cnt: '0};
            ev       = btn_dar_pkg::EV_PRESSED;
          end
        end
      end
      btn_dar_pkg::PH_WAIT_FIRST, btn_dar_pkg::PH_REPEAT: begin
        if (!b_pressed) begin
          wr_entry = '{phase: btn_dar_pkg::PH_REL_CAND, cnt: '0};
        end else if (CMP_W'(cnt_inc) == CMP_W'(rep_target)) begin
          wr_entry = '{phase: btn_dar_pkg::PH_REPEAT, cnt: '0};
          ev       = btn_dar_pkg::EV_REPEAT;
        end
      end
      default: begin
        if (b_pressed) begin
          wr_entry = '{phase: btn_dar_pkg::PH_PRESS_CAND, cnt: '0};
        end
      end
    endcase
  end

  always_comb begin
    acc_next = b_first ? '0 : acc;
    for (int i = 0; i < btn_dar_pkg::FIELDS; i++) begin
      if (i < NUM_BUTTONS && b_idx == IDX_W'(i)) begin
        acc_next[i*btn_dar_pkg::EV_W +: btn_dar_pkg::EV_W] = ev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      acc <= acc_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (b_valid && b_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_last) begin
      m_tdata <= {(16 - ACC_W)'(0), acc_next};
    end
  end

  ap_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_last) |-> !m_tvalid)
    else $error("result register overwritten");

  ap_hold_tick: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !(issue && at_last)) |-> !s_tready)
    else $error("new tick taken while current one is in progress");

  ap_pressed_src: assert property (@(posedge clk) disable iff (rst)
    (b_valid && ev == btn_dar_pkg::EV_PRESSED) |->
      (cur_entry.phase == btn_dar_pkg::PH_PRESS_CAND))
    else $error("pressed event outside press candidate");

  ap_result_follows: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_last) |=> m_tvalid)
    else $error("finished tick produced no result");

  ap_stage_follows: assert property (@(posedge clk) disable iff (rst)
    issue |=> (b_valid && b_idx == $past(idx)))
    else $error("issued button lost in update stage");

endmodule

`default_nettype wire
